// ===== src/cbsm_pkg.sv =====
// Shared types and constants for the cartridge bank-switch mapper.
package cbsm_pkg;

    // Bus action carried in the input tuser.
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_CPU   = 2'd1;
    localparam logic [1:0] ACT_PPU   = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    // Region codes carried in the output tuser.
    localparam logic [1:0] RG_PRG  = 2'd0;
    localparam logic [1:0] RG_WRAM = 2'd1;
    localparam logic [1:0] RG_NONE = 2'd2;
    localparam logic [1:0] RG_CHR  = 2'd3;

    // Configuration register indexes (paddr[3:2]).
    localparam logic [1:0] CFG_PRG_MASK    = 2'd0;
    localparam logic [1:0] CFG_CHR_MASK    = 2'd1;
    localparam logic [1:0] CFG_FOUR_SCREEN = 2'd2;

    // Register write decode on address bits 14..13.
    localparam logic [1:0] WR_SEL_BANK   = 2'd0;
    localparam logic [1:0] WR_SEL_MIRROR = 2'd1;

    localparam logic [7:0] FIXED_BANK_LOW  = 8'hFE;
    localparam logic [7:0] FIXED_BANK_HIGH = 8'hFF;

    localparam int unsigned NUM_BANKS = 8;
    localparam logic [7:0] BANK_RESET [NUM_BANKS] = '{
        8'd0, 8'd1, 8'd4, 8'd5, 8'd6, 8'd7, 8'd0, 8'd1
    };

    // Controller to datapath commands.
    typedef struct packed {
        logic load_in;
        logic exec;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic out_blocked;
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

endpackage

// ===== src/cartridge_bank_switch_mapper_core.sv =====
// Top level of the cartridge bank-switch mapper: stream ports, APB port, controller and datapath.
//
//  channel    | direction | payload
//  -----------+-----------+----------------------------------------------------
//  s_axis     | in        | tuser action; tdata bus_address, write_data
//  m_axis     | out       | tuser region; tdata mapped_address, wram flags, mirror
//  apb        | in/out    | prg_bank_mask, chr_bank_mask, four_screen
//
// Each beat is first captured, then decoded to update the mapper state and load the
// result register, as sequenced by the capture-then-execute controller.
// A new beat is taken while the previous result waits in the result register; the
// execute cycle waits only while that result is still held by m_axis_tready.
// Reset is synchronous: control state clears and the bank registers take their
// power-on values.
module cartridge_bank_switch_mapper_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [15:0] bus_address, [23:16] write_data
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] action
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [20:0] mapped_address, [21] wram_readable,
                                          // [22] wram_writable, [23] mirror_horizontal
    output logic [1:0]  o_m_axis_tuser,   // [1:0] region
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cbsm_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    cbsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_status   (status),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd)
    );

    cbsm_datapath u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_action            (i_s_axis_tuser),
        .i_bus_address       (i_s_axis_tdata[15:0]),
        .i_write_data        (i_s_axis_tdata[23:16]),
        .i_cfg_we            (cfg_we),
        .i_cfg_index         (paddr[3:2]),
        .i_cfg_wdata         (pwdata),
        .o_cfg_rdata         (prdata),
        .o_out_valid         (o_m_axis_tvalid),
        .i_out_ready         (i_m_axis_tready),
        .o_mapped_address    (o_m_axis_tdata[20:0]),
        .o_region            (o_m_axis_tuser),
        .o_wram_readable     (o_m_axis_tdata[21]),
        .o_wram_writable     (o_m_axis_tdata[22]),
        .o_mirror_horizontal (o_m_axis_tdata[23])
    );

    // Only one beat is in flight between capture and execute.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted while a beat is still being executed");

    // An execute cycle always leaves a result waiting downstream.
    a_exec_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec |=> o_m_axis_tvalid)
        else $error("executed beat produced no result");

    // A held result is never overwritten by the next execute.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !cmd.exec)
        else $error("result register overwritten while stalled");

    // A beat accepted into capture is executed no earlier than the next cycle.
    a_capture_before_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_in |-> !cmd.exec)
        else $error("capture and execute in the same cycle");

endmodule

// ===== src/cbsm_ctrl.sv =====
// Controller state machine: captures one beat, then executes it into the result register.
module cbsm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  cbsm_pkg::t_status i_status,
    output logic             o_in_ready,
    output cbsm_pkg::t_cmd   o_cmd
);
    import cbsm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                // Wait here while the previous result is still held downstream.
                if (!i_status.out_blocked) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/cbsm_datapath.sv =====
// Datapath: input capture, mapper state, address translation and result register.
module cbsm_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cbsm_pkg::t_cmd    i_cmd,
    output cbsm_pkg::t_status o_status,
    input  logic [1:0]        i_action,
    input  logic [15:0]       i_bus_address,
    input  logic [7:0]        i_write_data,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_wdata,
    output logic [31:0]       o_cfg_rdata,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [20:0]       o_mapped_address,
    output logic [1:0]        o_region,
    output logic              o_wram_readable,
    output logic              o_wram_writable,
    output logic              o_mirror_horizontal
);
    import cbsm_pkg::*;

    // Configuration
    logic [7:0] r_prg_mask;
    logic [7:0] r_chr_mask;
    logic       r_four_screen;

    // Captured input beat
    logic [1:0]  r_action;
    logic [15:0] r_addr;
    logic [7:0]  r_data;

    // Mapper state
    logic [7:0] r_bank_control;
    logic [7:0] r_banks [NUM_BANKS];
    logic [1:0] r_wram_control;
    logic       r_mirror;
    logic [7:0] n_bank_control;
    logic [1:0] n_wram_control;
    logic       n_mirror;
    logic       bank_we;
    logic [2:0] bank_widx;
    logic [7:0] bank_wdata;

    // Result register
    logic        r_out_valid;
    logic [20:0] r_mapped;
    logic [1:0]  r_region;
    logic        r_wram_rd;
    logic        r_wram_wr;
    logic        r_mirror_out;
    logic        n_out_valid;

    // Translation
    logic [2:0]  rd_idx;
    logic [7:0]  rd_bank;
    logic [1:0]  cpu_slot;
    logic [7:0]  prg_bank;
    logic        chr_hi;
    logic [7:0]  chr_bank;
    logic [20:0] n_mapped;
    logic [1:0]  n_region;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_mask    <= 8'hFF;
            r_chr_mask    <= 8'hFF;
            r_four_screen <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PRG_MASK:    r_prg_mask    <= i_cfg_wdata[7:0];
                CFG_CHR_MASK:    r_chr_mask    <= i_cfg_wdata[7:0];
                CFG_FOUR_SCREEN: r_four_screen <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (i_cfg_index)
            CFG_PRG_MASK:    o_cfg_rdata = {24'd0, r_prg_mask};
            CFG_CHR_MASK:    o_cfg_rdata = {24'd0, r_chr_mask};
            CFG_FOUR_SCREEN: o_cfg_rdata = {31'd0, r_four_screen};
            default:         o_cfg_rdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_action <= i_action;
            r_addr   <= i_bus_address;
            r_data   <= i_write_data;
        end
    end

    // Register write decode. Writes below $8000 and in $C000-$FFFF change nothing.
    always_comb begin
        n_bank_control = r_bank_control;
        n_wram_control = r_wram_control;
        n_mirror       = r_mirror;
        bank_we        = 1'b0;
        bank_widx      = r_bank_control[2:0];
        bank_wdata     = r_data;
        if (r_action == ACT_WRITE && r_addr[15] && !r_addr[14]) begin
            priority if (r_addr[13] == WR_SEL_BANK[0]) begin
                if (!r_addr[0]) begin
                    n_bank_control = r_data;
                end else begin
                    bank_we = 1'b1;
                    // The two 2K pattern banks are stored as halved bank numbers.
                    if (bank_widx[2:1] == 2'b00) begin
                        bank_wdata = {1'b0, r_data[7:1]};
                    end
                end
            end else if (r_addr[13] == WR_SEL_MIRROR[0]) begin
                if (!r_addr[0]) begin
                    if (!r_four_screen) begin
                        n_mirror = r_data[0];
                    end
                end else begin
                    n_wram_control = {r_data[6], r_data[7]};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_control <= '0;
            r_wram_control <= '0;
            r_mirror       <= 1'b0;
            r_banks        <= BANK_RESET;
        end else if (i_cmd.exec) begin
            r_bank_control <= n_bank_control;
            r_wram_control <= n_wram_control;
            r_mirror       <= n_mirror;
            if (bank_we) begin
                r_banks[bank_widx] <= bank_wdata;
            end
        end
    end

    // One bank register read per lookup; the index depends on the action.
    assign cpu_slot = (r_bank_control[6] && !r_addr[13]) ? (r_addr[14:13] ^ 2'b10)
                                                         : r_addr[14:13];
    assign chr_hi   = r_addr[12] ^ r_bank_control[7];

    always_comb begin
        if (r_action == ACT_CPU) begin
            rd_idx = {2'b11, cpu_slot[0]};
        end else if (!chr_hi) begin
            rd_idx = {2'b00, r_addr[11]};
        end else begin
            rd_idx = 3'd2 + {1'b0, r_addr[11:10]};
        end
    end

    assign rd_bank = r_banks[rd_idx];

    always_comb begin
        unique case (cpu_slot)
            2'd0, 2'd1: prg_bank = rd_bank & r_prg_mask;
            2'd2:       prg_bank = FIXED_BANK_LOW & r_prg_mask;
            default:    prg_bank = FIXED_BANK_HIGH & r_prg_mask;
        endcase
    end

    assign chr_bank = (chr_hi ? rd_bank : {rd_bank[6:0], r_addr[10]}) & r_chr_mask;

    always_comb begin
        n_mapped = '0;
        n_region = RG_NONE;
        unique case (r_action)
            ACT_CPU: begin
                if (r_addr[15]) begin
                    n_mapped = {prg_bank, r_addr[12:0]};
                    n_region = RG_PRG;
                end else if (r_addr[14:13] == 2'b11) begin
                    n_mapped = {8'd0, r_addr[12:0]};
                    n_region = RG_WRAM;
                end
            end
            ACT_PPU: begin
                if (!r_addr[13]) begin
                    n_mapped = {3'd0, chr_bank, r_addr[9:0]};
                    n_region = RG_CHR;
                end
            end
            ACT_WRITE, ACT_NONE: begin
            end
            default: begin
            end
        endcase
    end

    assign o_status.out_blocked = r_out_valid && !i_out_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Status fields report the state as it stands after this beat.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_mapped     <= n_mapped;
            r_region     <= n_region;
            r_wram_rd    <= n_wram_control[0];
            r_wram_wr    <= n_wram_control[0] && !n_wram_control[1];
            r_mirror_out <= n_mirror;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_mapped_address    = r_mapped;
    assign o_region            = r_region;
    assign o_wram_readable     = r_wram_rd;
    assign o_wram_writable     = r_wram_wr;
    assign o_mirror_horizontal = r_mirror_out;

endmodule
